// ----- design/tid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tid_pkg
// Shared types and constants of the reservation station issue core.
// ----------------------------------------------------------------------------
package tid_pkg;

    localparam int ADD_STATIONS = 3;
    localparam int MUL_STATIONS = 2;
    localparam int NST          = ADD_STATIONS + MUL_STATIONS;
    localparam int NUM_REGS     = 5;
    localparam int DATA_WIDTH   = 32;
    localparam int TAG_W        = 3;
    localparam int LAT_W        = 8;
    localparam int DIV_CNT_W    = $clog2(DATA_WIDTH);

    localparam logic [1:0] CFG_ADD_LAT = 2'd0;
    localparam logic [1:0] CFG_MUL_LAT = 2'd1;
    localparam logic [1:0] CFG_DIV_LAT = 2'd2;

    localparam logic [LAT_W-1:0] ADD_LAT_RST = 8'd2;
    localparam logic [LAT_W-1:0] MUL_LAT_RST = 8'd10;
    localparam logic [LAT_W-1:0] DIV_LAT_RST = 8'd40;

    typedef enum logic [2:0] {
        OPC_ADD  = 3'd0,
        OPC_SUB  = 3'd1,
        OPC_ADDI = 3'd2,
        OPC_MUL  = 3'd3,
        OPC_DIV  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_EXEC,
        S_DIV,
        S_WB,
        S_ISSUE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic count;
        logic exec;
        logic div_step;
        logic wb;
        logic issue;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_fire;
        logic mul_is_div;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- design/tomasulo_issue_dispatch_writeback.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tomasulo_issue_dispatch_writeback
// Reservation-station core: writeback, dispatch and issue of one machine
// cycle per input word.
// ----------------------------------------------------------------------------
// Each accepted input word is one machine cycle and yields exactly one output
// word. A word passes through the count, execute, writeback, issue and output
// steps on its way to the output register, and the next input word is taken
// only once it has left the output step. A word in which the mul/div unit
// writes back a divide also passes through a divide step, because the quotient
// comes from a one-bit-per-cycle divider run before writeback. While the output
// register is held by a stall, the sequencer waits in its output step.
// The input is taken only while the sequencer is idle; a finished word waits
// in the output register while the next input is accepted. The latency
// registers are written through the configuration port, index 0 add, 1 mul,
// 2 div; the port is always ready.
module tomasulo_issue_dispatch_writeback (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_offer_valid,
    input  logic [2:0]         i_opcode,
    input  logic [2:0]         i_dest_reg,
    input  logic [2:0]         i_src1_reg,
    input  logic [2:0]         i_src2_reg,
    input  logic signed [11:0] i_immediate,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_issued,
    output logic               o_add_done,
    output logic [1:0]         o_add_done_station,
    output logic signed [31:0] o_add_done_value,
    output logic               o_mul_done,
    output logic [2:0]         o_mul_done_station,
    output logic signed [31:0] o_mul_done_value,
    output logic               o_machine_empty
);

    tid_pkg::t_dp_cmd    cmd;
    tid_pkg::t_dp_status sts;

    assign o_stall     = !cmd.accept;
    assign o_cfg_ready = 1'b1;

    tid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tid_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_valid            (i_valid),
        .i_offer_valid      (i_offer_valid),
        .i_opcode           (i_opcode),
        .i_dest_reg         (i_dest_reg),
        .i_src1_reg         (i_src1_reg),
        .i_src2_reg         (i_src2_reg),
        .i_immediate        (i_immediate),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_issued           (o_issued),
        .o_add_done         (o_add_done),
        .o_add_done_station (o_add_done_station),
        .o_add_done_value   (o_add_done_value),
        .o_mul_done         (o_mul_done),
        .o_mul_done_station (o_mul_done_station),
        .o_mul_done_value   (o_mul_done_value),
        .o_machine_empty    (o_machine_empty)
    );

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");
    a_div_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> sts.mul_fire)
        else $error("divider stepping without a mul/div writeback");
    a_accept_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> cmd.count)
        else $error("accepted word did not start its cycle");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule

// ----- design/tid_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tid_ctrl
// Sequencer that walks one machine cycle through count, execute, divide (for a
// divide writeback), writeback, dispatch/issue and result delivery.
// ----------------------------------------------------------------------------
module tid_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  tid_pkg::t_dp_status i_sts,
    output tid_pkg::t_dp_cmd    o_cmd
);

    tid_pkg::t_state r_state;
    tid_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tid_pkg::S_IDLE: begin
                if (i_valid) n_state = tid_pkg::S_COUNT;
            end
            tid_pkg::S_COUNT: n_state = tid_pkg::S_EXEC;
            tid_pkg::S_EXEC: begin
                if (i_sts.mul_fire && i_sts.mul_is_div) n_state = tid_pkg::S_DIV;
                else n_state = tid_pkg::S_WB;
            end
            tid_pkg::S_DIV: begin
                if (i_sts.div_last) n_state = tid_pkg::S_WB;
            end
            tid_pkg::S_WB:    n_state = tid_pkg::S_ISSUE;
            tid_pkg::S_ISSUE: n_state = tid_pkg::S_OUT;
            tid_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = tid_pkg::S_IDLE;
            end
            default: n_state = tid_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tid_pkg::S_IDLE:  o_cmd.accept   = 1'b1;
            tid_pkg::S_COUNT: o_cmd.count    = 1'b1;
            tid_pkg::S_EXEC:  o_cmd.exec     = 1'b1;
            tid_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            tid_pkg::S_WB:    o_cmd.wb       = 1'b1;
            tid_pkg::S_ISSUE: o_cmd.issue    = 1'b1;
            tid_pkg::S_OUT:   o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- design/tid_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tid_dp
// Datapath: reservation stations, rename table, register file, the two
// execution units with a bit-serial divider, and the result register.
// ----------------------------------------------------------------------------
module tid_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tid_pkg::t_dp_cmd    i_cmd,
    output tid_pkg::t_dp_status o_sts,
    input  logic                i_valid,
    input  logic                i_offer_valid,
    input  logic [2:0]          i_opcode,
    input  logic [2:0]          i_dest_reg,
    input  logic [2:0]          i_src1_reg,
    input  logic [2:0]          i_src2_reg,
    input  logic signed [11:0]  i_immediate,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_issued,
    output logic                o_add_done,
    output logic [1:0]          o_add_done_station,
    output logic signed [31:0]  o_add_done_value,
    output logic                o_mul_done,
    output logic [2:0]          o_mul_done_station,
    output logic signed [31:0]  o_mul_done_value,
    output logic                o_machine_empty
);

    localparam int DW  = tid_pkg::DATA_WIDTH;
    localparam int TW  = tid_pkg::TAG_W;
    localparam int LW  = tid_pkg::LAT_W;
    localparam int NST = tid_pkg::NST;
    localparam int NR  = tid_pkg::NUM_REGS;
    localparam int AS  = tid_pkg::ADD_STATIONS;

    // Latched input word.
    logic              r_in_offer;
    logic [2:0]        r_in_opcode;
    logic [2:0]        r_in_dest;
    logic [2:0]        r_in_src1;
    logic [2:0]        r_in_src2;
    logic [11:0]       r_in_imm;

    logic [LW-1:0]     r_add_lat;
    logic [LW-1:0]     r_mul_lat;
    logic [LW-1:0]     r_div_lat;

    logic                  r_busy  [NST];
    tid_pkg::t_alu_op      r_op    [NST];
    logic [TW-1:0]         r_tag1  [NST];
    logic [TW-1:0]         r_tag2  [NST];
    logic [DW-1:0]         r_val1  [NST];
    logic [DW-1:0]         r_val2  [NST];
    logic [TW-1:0]         r_rename[NR];
    logic [DW-1:0]         r_regs  [NR];

    // Execution units keep a copy of their operands from dispatch.
    logic                  r_add_busy;
    logic [TW-1:0]         r_add_st;
    logic [LW-1:0]         r_add_cnt;
    tid_pkg::t_alu_op      r_add_op;
    logic [DW-1:0]         r_add_a;
    logic [DW-1:0]         r_add_b;
    logic                  r_add_fire;
    logic                  r_mul_busy;
    logic [TW-1:0]         r_mul_st;
    logic [LW-1:0]         r_mul_cnt;
    tid_pkg::t_alu_op      r_mul_op;
    logic [DW-1:0]         r_mul_a;
    logic [DW-1:0]         r_mul_b;
    logic                  r_mul_fire;
    logic [DW-1:0]         r_prod;

    logic [DW-1:0]             r_div_rem;
    logic [DW-1:0]             r_div_quo;
    logic [DW-1:0]             r_div_den;
    logic                      r_div_neg;
    logic [tid_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic              r_res_issued;
    logic              r_res_add_done;
    logic [TW-1:0]     r_res_add_st;
    logic [DW-1:0]     r_res_add_val;
    logic              r_res_mul_done;
    logic [TW-1:0]     r_res_mul_st;
    logic [DW-1:0]     r_res_mul_val;

    logic              r_o_valid;
    logic              r_o_issued;
    logic              r_o_add_done;
    logic [1:0]        r_o_add_st;
    logic [DW-1:0]     r_o_add_val;
    logic              r_o_mul_done;
    logic [2:0]        r_o_mul_st;
    logic [DW-1:0]     r_o_mul_val;
    logic              r_o_empty;

    logic [DW-1:0]     add_val;
    logic [DW-1:0]     mul_val;
    logic [DW-1:0]     div_val;
    logic [DW:0]       div_shift;
    logic [DW:0]       div_diff;
    logic [DW-1:0]     mag_a;
    logic [DW-1:0]     mag_b;
    logic              any_busy;

    logic              add_pick_ok;
    logic [TW-1:0]     add_pick;
    logic              mul_pick_ok;
    logic [TW-1:0]     mul_pick;
    tid_pkg::t_alu_op  add_pick_op;
    logic [DW-1:0]     add_pick_a;
    logic [DW-1:0]     add_pick_b;
    tid_pkg::t_alu_op  mul_pick_op;
    logic [DW-1:0]     mul_pick_a;
    logic [DW-1:0]     mul_pick_b;

    logic              iss_ok;
    logic [TW-1:0]     iss_st;
    logic              iss_add_cls;
    tid_pkg::t_alu_op  iss_op;
    logic [TW-1:0]     s1_tag;
    logic [DW-1:0]     s1_val;
    logic [TW-1:0]     s2_tag;
    logic [DW-1:0]     s2_val;
    logic [DW-1:0]     imm_ext;

    assign add_val = (r_add_op == tid_pkg::ALU_SUB) ? r_add_a - r_add_b : r_add_a + r_add_b;

    assign mag_a     = r_mul_a[DW-1] ? DW'(-r_mul_a) : r_mul_a;
    assign mag_b     = r_mul_b[DW-1] ? DW'(-r_mul_b) : r_mul_b;
    assign div_shift = {r_div_rem, r_div_quo[DW-1]};
    assign div_diff  = div_shift - {1'b0, r_div_den};
    // A zero divisor leaves an all-ones quotient, so it is caught separately.
    assign div_val   = (r_div_den == '0) ? '0 :
                       (r_div_neg ? DW'(-r_div_quo) : r_div_quo);
    assign mul_val   = (r_mul_op == tid_pkg::ALU_DIV) ? div_val : r_prod;

    always_comb begin
        any_busy = 1'b0;
        for (int j = 0; j < NST; j++) any_busy = any_busy | r_busy[j];
    end

    // Highest-numbered ready station per unit.
    always_comb begin
        add_pick_ok = 1'b0;
        add_pick    = '0;
        add_pick_op = tid_pkg::ALU_ADD;
        add_pick_a  = '0;
        add_pick_b  = '0;
        for (int j = 0; j < AS; j++) begin
            if (r_busy[j] && r_tag1[j] == '0 && r_tag2[j] == '0) begin
                add_pick_ok = 1'b1;
                add_pick    = TW'(j + 1);
                add_pick_op = r_op[j];
                add_pick_a  = r_val1[j];
                add_pick_b  = r_val2[j];
            end
        end
        mul_pick_ok = 1'b0;
        mul_pick    = '0;
        mul_pick_op = tid_pkg::ALU_MUL;
        mul_pick_a  = '0;
        mul_pick_b  = '0;
        for (int j = AS; j < NST; j++) begin
            if (r_busy[j] && r_tag1[j] == '0 && r_tag2[j] == '0) begin
                mul_pick_ok = 1'b1;
                mul_pick    = TW'(j + 1);
                mul_pick_op = r_op[j];
                mul_pick_a  = r_val1[j];
                mul_pick_b  = r_val2[j];
            end
        end
    end

    // Issue: lowest free station of the class and the operand lookup.
    always_comb begin
        iss_add_cls = (r_in_opcode <= tid_pkg::OPC_ADDI);
        iss_ok      = 1'b0;
        iss_st      = '0;
        for (int j = NST - 1; j >= 0; j--) begin
            if (!r_busy[j] && ((j < AS) == iss_add_cls)) begin
                iss_ok = 1'b1;
                iss_st = TW'(j + 1);
            end
        end
        iss_ok = iss_ok && r_in_offer && (r_in_opcode <= tid_pkg::OPC_DIV);
        unique case (r_in_opcode)
            tid_pkg::OPC_SUB: iss_op = tid_pkg::ALU_SUB;
            tid_pkg::OPC_MUL: iss_op = tid_pkg::ALU_MUL;
            tid_pkg::OPC_DIV: iss_op = tid_pkg::ALU_DIV;
            default:          iss_op = tid_pkg::ALU_ADD;
        endcase
        s1_tag = '0;
        s1_val = '0;
        s2_tag = '0;
        s2_val = '0;
        for (int k = 0; k < NR; k++) begin
            if (r_in_src1 == 3'(k + 1)) begin
                s1_tag = r_rename[k];
                s1_val = (r_rename[k] == '0) ? r_regs[k] : '0;
            end
            if (r_in_src2 == 3'(k + 1)) begin
                s2_tag = r_rename[k];
                s2_val = (r_rename[k] == '0) ? r_regs[k] : '0;
            end
        end
        imm_ext = DW'(signed'(r_in_imm));
        if (r_in_opcode == tid_pkg::OPC_ADDI) begin
            s2_tag = '0;
            s2_val = imm_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_valid) begin
            r_in_offer  <= i_offer_valid;
            r_in_opcode <= i_opcode;
            r_in_dest   <= i_dest_reg;
            r_in_src1   <= i_src1_reg;
            r_in_src2   <= i_src2_reg;
            r_in_imm    <= i_immediate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_lat <= tid_pkg::ADD_LAT_RST;
            r_mul_lat <= tid_pkg::MUL_LAT_RST;
            r_div_lat <= tid_pkg::DIV_LAT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tid_pkg::CFG_ADD_LAT: r_add_lat <= i_cfg_data;
                tid_pkg::CFG_MUL_LAT: r_mul_lat <= i_cfg_data;
                tid_pkg::CFG_DIV_LAT: r_div_lat <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Station, rename and register file state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NST; j++) begin
                r_busy[j] <= 1'b0;
                r_op[j]   <= tid_pkg::ALU_ADD;
                r_tag1[j] <= '0;
                r_tag2[j] <= '0;
            end
            for (int k = 0; k < NR; k++) begin
                r_rename[k] <= '0;
                r_regs[k]   <= DW'(k * 2);
            end
        end else if (i_cmd.wb) begin
            for (int k = 0; k < NR; k++) begin
                if (r_add_fire && r_rename[k] == r_add_st) begin
                    r_rename[k] <= '0;
                    r_regs[k]   <= add_val;
                end else if (r_mul_fire && r_rename[k] == r_mul_st) begin
                    r_rename[k] <= '0;
                    r_regs[k]   <= mul_val;
                end
            end
            for (int j = 0; j < NST; j++) begin
                if (r_add_fire && r_tag1[j] == r_add_st) begin
                    r_tag1[j] <= '0;
                    r_val1[j] <= add_val;
                end else if (r_mul_fire && r_tag1[j] == r_mul_st) begin
                    r_tag1[j] <= '0;
                    r_val1[j] <= mul_val;
                end
                if (r_add_fire && r_tag2[j] == r_add_st) begin
                    r_tag2[j] <= '0;
                    r_val2[j] <= add_val;
                end else if (r_mul_fire && r_tag2[j] == r_mul_st) begin
                    r_tag2[j] <= '0;
                    r_val2[j] <= mul_val;
                end
                if ((r_add_fire && r_add_st == TW'(j + 1)) ||
                    (r_mul_fire && r_mul_st == TW'(j + 1))) begin
                    r_busy[j] <= 1'b0;
                    r_op[j]   <= tid_pkg::ALU_ADD;
                end
            end
        end else if (i_cmd.issue && iss_ok) begin
            for (int j = 0; j < NST; j++) begin
                if (iss_st == TW'(j + 1)) begin
                    r_busy[j] <= 1'b1;
                    r_op[j]   <= iss_op;
                    r_tag1[j] <= s1_tag;
                    r_val1[j] <= s1_val;
                    r_tag2[j] <= s2_tag;
                    r_val2[j] <= s2_val;
                end
            end
            for (int k = 0; k < NR; k++) begin
                if (r_in_dest == 3'(k + 1)) r_rename[k] <= iss_st;
            end
        end
    end

    // Execution units.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_busy <= 1'b0;
            r_add_st   <= '0;
            r_add_cnt  <= '0;
            r_add_fire <= 1'b0;
            r_mul_busy <= 1'b0;
            r_mul_st   <= '0;
            r_mul_cnt  <= '0;
            r_mul_fire <= 1'b0;
        end else if (i_cmd.count) begin
            r_add_fire <= r_add_busy && (r_add_cnt == LW'(1));
            r_mul_fire <= r_mul_busy && (r_mul_cnt == LW'(1));
            if (r_add_busy) r_add_cnt <= r_add_cnt - LW'(1);
            if (r_mul_busy) r_mul_cnt <= r_mul_cnt - LW'(1);
        end else if (i_cmd.wb) begin
            if (r_add_fire) begin
                r_add_busy <= 1'b0;
                r_add_st   <= '0;
            end
            if (r_mul_fire) begin
                r_mul_busy <= 1'b0;
                r_mul_st   <= '0;
            end
        end else if (i_cmd.issue) begin
            if (!r_add_busy && add_pick_ok) begin
                r_add_busy <= 1'b1;
                r_add_st   <= add_pick;
                r_add_cnt  <= (r_add_lat == '0) ? LW'(1) : r_add_lat;
            end
            if (!r_mul_busy && mul_pick_ok) begin
                r_mul_busy <= 1'b1;
                r_mul_st   <= mul_pick;
                if (mul_pick_op == tid_pkg::ALU_MUL)
                    r_mul_cnt <= (r_mul_lat == '0) ? LW'(1) : r_mul_lat;
                else
                    r_mul_cnt <= (r_div_lat == '0) ? LW'(1) : r_div_lat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue && !r_add_busy && add_pick_ok) begin
            r_add_op <= add_pick_op;
            r_add_a  <= add_pick_a;
            r_add_b  <= add_pick_b;
        end
        if (i_cmd.issue && !r_mul_busy && mul_pick_ok) begin
            r_mul_op <= mul_pick_op;
            r_mul_a  <= mul_pick_a;
            r_mul_b  <= mul_pick_b;
        end
        if (i_cmd.exec) begin
            r_prod    <= DW'(r_mul_a * r_mul_b);
            r_div_rem <= '0;
            r_div_quo <= mag_a;
            r_div_den <= mag_b;
            r_div_neg <= r_mul_a[DW-1] ^ r_mul_b[DW-1];
        end else if (i_cmd.div_step) begin
            if (!div_diff[DW]) begin
                r_div_rem <= div_diff[DW-1:0];
                r_div_quo <= {r_div_quo[DW-2:0], 1'b1};
            end else begin
                r_div_rem <= div_shift[DW-1:0];
                r_div_quo <= {r_div_quo[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.exec) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Per-word result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_res_add_done <= r_add_fire;
            r_res_add_st   <= r_add_fire ? r_add_st : '0;
            r_res_add_val  <= r_add_fire ? add_val : '0;
            r_res_mul_done <= r_mul_fire;
            r_res_mul_st   <= r_mul_fire ? r_mul_st : '0;
            r_res_mul_val  <= r_mul_fire ? mul_val : '0;
        end
        if (i_cmd.issue) r_res_issued <= iss_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_issued   <= r_res_issued;
            r_o_add_done <= r_res_add_done;
            r_o_add_st   <= r_res_add_st[1:0];
            r_o_add_val  <= r_res_add_val;
            r_o_mul_done <= r_res_mul_done;
            r_o_mul_st   <= r_res_mul_st;
            r_o_mul_val  <= r_res_mul_val;
            r_o_empty    <= !any_busy;
        end
    end

    assign o_sts.mul_fire   = r_mul_fire;
    assign o_sts.mul_is_div = (r_mul_op == tid_pkg::ALU_DIV);
    assign o_sts.div_last   = (r_div_cnt == tid_pkg::DIV_CNT_W'(DW - 1));
    assign o_sts.out_free   = !r_o_valid || !i_stall;

    assign o_valid            = r_o_valid;
    assign o_issued           = r_o_issued;
    assign o_add_done         = r_o_add_done;
    assign o_add_done_station = r_o_add_st;
    assign o_add_done_value   = r_o_add_val;
    assign o_mul_done         = r_o_mul_done;
    assign o_mul_done_station = r_o_mul_st;
    assign o_mul_done_value   = r_o_mul_val;
    assign o_machine_empty    = r_o_empty;

endmodule

// ----- verif/tid_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tid_scoreboard
// Watches the issue core's channels, predicts each output word from its own
// model of the reservation stations and units, and compares field by field.
// ----------------------------------------------------------------------------
module tid_scoreboard (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic               i_offer_valid,
    input  logic [2:0]         i_opcode,
    input  logic [2:0]         i_dest_reg,
    input  logic [2:0]         i_src1_reg,
    input  logic [2:0]         i_src2_reg,
    input  logic [11:0]        i_immediate,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_issued,
    input  logic               i_add_done,
    input  logic [1:0]         i_add_done_station,
    input  logic [31:0]        i_add_done_value,
    input  logic               i_mul_done,
    input  logic [2:0]         i_mul_done_station,
    input  logic [31:0]        i_mul_done_value,
    input  logic               i_machine_empty,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_words_in,
    output int                 o_words_out
);

    typedef struct packed {
        logic        issued;
        logic        add_done;
        logic [1:0]  add_st;
        logic [31:0] add_val;
        logic        mul_done;
        logic [2:0]  mul_st;
        logic [31:0] mul_val;
        logic        empty;
    } t_word;

    logic [7:0]       lat_add, lat_mul, lat_div;
    logic             rs_busy [1:tid_pkg::NST];
    tid_pkg::t_alu_op rs_op   [1:tid_pkg::NST];
    logic [2:0]       rs_tag1 [1:tid_pkg::NST];
    logic [2:0]       rs_tag2 [1:tid_pkg::NST];
    logic [31:0]      rs_val1 [1:tid_pkg::NST];
    logic [31:0]      rs_val2 [1:tid_pkg::NST];
    logic [2:0]       rat     [1:tid_pkg::NUM_REGS];
    logic [31:0]      regs    [1:tid_pkg::NUM_REGS];
    logic             au_busy, mu_busy;
    logic [2:0]       au_st, mu_st;
    logic [7:0]       au_cnt, mu_cnt;
    t_word            expected_words [$];

    assign o_pending = expected_words.size();

    function automatic logic [31:0] compute(tid_pkg::t_alu_op op, logic [31:0] a,
                                            logic [31:0] b);
        logic [31:0] ma, mb, q;
        case (op)
            tid_pkg::ALU_ADD: return a + b;
            tid_pkg::ALU_SUB: return a - b;
            tid_pkg::ALU_MUL: return a * b;
            default: begin
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                if (mb == 0) return 32'd0;
                q = ma / mb;
                return (a[31] != b[31]) ? -q : q;
            end
        endcase
    endfunction

    task automatic retire(input logic [2:0] s, output logic [31:0] v);
        v = compute(rs_op[s], rs_val1[s], rs_val2[s]);
        for (int r = 1; r <= tid_pkg::NUM_REGS; r++)
            if (rat[r] == s) begin
                rat[r] = 0;
                regs[r] = v;
            end
        for (int i = 1; i <= tid_pkg::NST; i++) begin
            if (rs_tag1[i] == s) begin
                rs_tag1[i] = 0;
                rs_val1[i] = v;
            end
            if (rs_tag2[i] == s) begin
                rs_tag2[i] = 0;
                rs_val2[i] = v;
            end
        end
        rs_busy[s] = 0;
        rs_op[s] = tid_pkg::ALU_ADD;
        rs_tag1[s] = 0;
        rs_tag2[s] = 0;
    endtask

    task automatic read_reg(input logic [2:0] r, output logic [2:0] tag,
                            output logic [31:0] val);
        tag = 0;
        val = 0;
        if (r >= 1 && r <= tid_pkg::NUM_REGS) begin
            if (rat[r] != 0) tag = rat[r];
            else val = regs[r];
        end
    endtask

    function automatic int ready_station(int lo, int hi);
        for (int i = hi; i >= lo; i--)
            if (rs_busy[i] && rs_tag1[i] == 0 && rs_tag2[i] == 0) return i;
        return 0;
    endfunction

    task automatic predict_cycle();
        t_word       w;
        int          p, lo, hi;
        logic [31:0] v;
        logic [7:0]  lat;
        w = '0;
        if (au_busy) begin
            au_cnt--;
            if (au_cnt == 0) begin
                w.add_done = 1;
                w.add_st = au_st[1:0];
                retire(au_st, v);
                w.add_val = v;
                au_busy = 0;
                au_st = 0;
            end
        end
        if (mu_busy) begin
            mu_cnt--;
            if (mu_cnt == 0) begin
                w.mul_done = 1;
                w.mul_st = mu_st;
                retire(mu_st, v);
                w.mul_val = v;
                mu_busy = 0;
                mu_st = 0;
            end
        end
        if (!au_busy) begin
            p = ready_station(1, tid_pkg::ADD_STATIONS);
            if (p != 0) begin
                au_busy = 1;
                au_st = 3'(p);
                au_cnt = (lat_add == 0) ? 8'd1 : lat_add;
            end
        end
        if (!mu_busy) begin
            p = ready_station(tid_pkg::ADD_STATIONS + 1, tid_pkg::NST);
            if (p != 0) begin
                mu_busy = 1;
                mu_st = 3'(p);
                lat = (rs_op[p] == tid_pkg::ALU_MUL) ? lat_mul : lat_div;
                mu_cnt = (lat == 0) ? 8'd1 : lat;
            end
        end
        if (i_offer_valid && i_opcode <= tid_pkg::OPC_DIV) begin
            lo = (i_opcode <= tid_pkg::OPC_ADDI) ? 1 : tid_pkg::ADD_STATIONS + 1;
            hi = (i_opcode <= tid_pkg::OPC_ADDI) ? tid_pkg::ADD_STATIONS : tid_pkg::NST;
            for (int i = lo; i <= hi; i++) begin
                if (!rs_busy[i]) begin
                    rs_busy[i] = 1;
                    case (i_opcode)
                        tid_pkg::OPC_SUB: rs_op[i] = tid_pkg::ALU_SUB;
                        tid_pkg::OPC_MUL: rs_op[i] = tid_pkg::ALU_MUL;
                        tid_pkg::OPC_DIV: rs_op[i] = tid_pkg::ALU_DIV;
                        default:          rs_op[i] = tid_pkg::ALU_ADD;
                    endcase
                    read_reg(i_src1_reg, rs_tag1[i], rs_val1[i]);
                    if (i_opcode == tid_pkg::OPC_ADDI) begin
                        rs_tag2[i] = 0;
                        rs_val2[i] = {{20{i_immediate[11]}}, i_immediate};
                    end else begin
                        read_reg(i_src2_reg, rs_tag2[i], rs_val2[i]);
                    end
                    if (i_dest_reg >= 1 && i_dest_reg <= tid_pkg::NUM_REGS)
                        rat[i_dest_reg] = 3'(i);
                    w.issued = 1;
                    break;
                end
            end
        end
        w.empty = 1;
        for (int i = 1; i <= tid_pkg::NST; i++)
            if (rs_busy[i]) w.empty = 0;
        expected_words = {expected_words, w};
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("MISMATCH word %0d %s: got %0h expected %0h", o_words_out, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            lat_add = tid_pkg::ADD_LAT_RST;
            lat_mul = tid_pkg::MUL_LAT_RST;
            lat_div = tid_pkg::DIV_LAT_RST;
            for (int i = 1; i <= tid_pkg::NST; i++) begin
                rs_busy[i] = 0;
                rs_op[i] = tid_pkg::ALU_ADD;
                rs_tag1[i] = 0;
                rs_tag2[i] = 0;
                rs_val1[i] = 0;
                rs_val2[i] = 0;
            end
            for (int r = 1; r <= tid_pkg::NUM_REGS; r++) begin
                rat[r] = 0;
                regs[r] = 32'((r - 1) * 2);
            end
            au_busy = 0; mu_busy = 0;
            au_st = 0; mu_st = 0;
            au_cnt = 0; mu_cnt = 0;
            expected_words.delete();
            o_errors = 0;
            o_words_in = 0;
            o_words_out = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tid_pkg::CFG_ADD_LAT: lat_add = i_cfg_data;
                    tid_pkg::CFG_MUL_LAT: lat_mul = i_cfg_data;
                    tid_pkg::CFG_DIV_LAT: lat_div = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report("unexpected output word", 32'd0, 32'd0);
                end else begin
                    w = expected_words.pop_front();
                    if (i_issued !== w.issued)
                        report("issued", 32'(i_issued), 32'(w.issued));
                    if (i_add_done !== w.add_done)
                        report("add_done", 32'(i_add_done), 32'(w.add_done));
                    if (i_add_done_station !== w.add_st)
                        report("add_done_station", 32'(i_add_done_station), 32'(w.add_st));
                    if (i_add_done_value !== w.add_val)
                        report("add_done_value", i_add_done_value, w.add_val);
                    if (i_mul_done !== w.mul_done)
                        report("mul_done", 32'(i_mul_done), 32'(w.mul_done));
                    if (i_mul_done_station !== w.mul_st)
                        report("mul_done_station", 32'(i_mul_done_station), 32'(w.mul_st));
                    if (i_mul_done_value !== w.mul_val)
                        report("mul_done_value", i_mul_done_value, w.mul_val);
                    if (i_machine_empty !== w.empty)
                        report("machine_empty", 32'(i_machine_empty), 32'(w.empty));
                end
                o_words_out++;
            end
            if (i_valid && !i_stall_in) begin
                predict_cycle();
                o_words_in++;
            end
        end
    end

endmodule

// ----- verif/tb_tomasulo_issue_dispatch_writeback.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tomasulo_issue_dispatch_writeback
// Drives machine-cycle words and latency writes into the issue core with
// random idling on both sides; the scoreboard predicts and checks outputs.
// ----------------------------------------------------------------------------
module tb_tomasulo_issue_dispatch_writeback;

    localparam int WATCHDOG_LIMIT = 20000;
    // Opcode codes past the last operation, which the core must ignore.
    localparam logic [2:0] OPC_BAD_FIRST = 3'd5;
    localparam logic [2:0] OPC_BAD_LAST  = 3'd7;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_offer_valid = 0;
    logic [2:0]  i_opcode = 0;
    logic [2:0]  i_dest_reg = 0;
    logic [2:0]  i_src1_reg = 0;
    logic [2:0]  i_src2_reg = 0;
    logic [11:0] i_immediate = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [7:0]  i_cfg_data = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic        o_issued, o_add_done, o_mul_done, o_machine_empty;
    logic [1:0]  o_add_done_station;
    logic [2:0]  o_mul_done_station;
    logic [31:0] o_add_done_value, o_mul_done_value;
    int          errors, pending, words_in, words_out;
    int          idle_cycles = 0;
    bit          calm;
    int          cycles_sent;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    tomasulo_issue_dispatch_writeback dut (.*);

    tid_scoreboard scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_offer_valid(i_offer_valid), .i_opcode(i_opcode), .i_dest_reg(i_dest_reg),
        .i_src1_reg(i_src1_reg), .i_src2_reg(i_src2_reg), .i_immediate(i_immediate),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_issued(o_issued), .i_add_done(o_add_done),
        .i_add_done_station(o_add_done_station), .i_add_done_value(o_add_done_value),
        .i_mul_done(o_mul_done), .i_mul_done_station(o_mul_done_station),
        .i_mul_done_value(o_mul_done_value), .i_machine_empty(o_machine_empty),
        .o_errors(errors), .o_pending(pending), .o_words_in(words_in),
        .o_words_out(words_out)
    );

    // Receiver stalls at random except during the calm stretch.
    always @(posedge i_clk)
        i_stall <= !calm && ($urandom_range(0, 99) < 11);

    // Watchdog: counts cycles with no word moving on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("tomasulo_issue_dispatch_writeback verification failed");
            $finish;
        end
    end

    // Valid stays up after the accepting edge; the next call replaces the word, or drain() drops it.
    task automatic send_cycle(input logic ov, input logic [2:0] op, input logic [2:0] d,
                              input logic [2:0] s1, input logic [2:0] s2,
                              input logic [11:0] imm);
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_offer_valid <= ov;
        i_opcode <= op;
        i_dest_reg <= d;
        i_src1_reg <= s1;
        i_src2_reg <= s2;
        i_immediate <= imm;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        cycles_sent++;
    endtask

    task automatic write_latency(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Mostly legal instructions on the real registers; a few odd opcodes,
    // out-of-range register numbers and empty cycles are mixed in.
    task automatic send_random();
        logic [2:0] op, d, s1, s2;
        int k;
        k = $urandom_range(0, 99);
        op = (k < 4) ? 3'($urandom_range(OPC_BAD_FIRST, OPC_BAD_LAST)) :
                       3'($urandom_range(tid_pkg::OPC_ADD, tid_pkg::OPC_DIV));
        d  = ($urandom_range(0, 19) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
        s1 = ($urandom_range(0, 19) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
        s2 = ($urandom_range(0, 19) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
        send_cycle($urandom_range(0, 99) < 80, op, d, s1, s2, 12'($urandom));
    endtask

    task automatic random_phase(input int n, input logic [7:0] la, input logic [7:0] lm,
                                input logic [7:0] ld);
        drain();
        write_latency(tid_pkg::CFG_ADD_LAT, la);
        write_latency(tid_pkg::CFG_MUL_LAT, lm);
        write_latency(tid_pkg::CFG_DIV_LAT, ld);
        repeat (n) send_random();
    endtask

    initial begin
        calm = 0;
        cycles_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, every operation and the special cases.
        send_cycle(1, tid_pkg::OPC_ADDI, 3'd1, 3'd5, 3'd0, 12'h800);
        send_cycle(1, tid_pkg::OPC_ADDI, 3'd2, 3'd0, 3'd0, 12'h7ff);
        send_cycle(1, tid_pkg::OPC_SUB, 3'd3, 3'd1, 3'd2, 12'h000);
        send_cycle(1, tid_pkg::OPC_ADD, 3'd4, 3'd3, 3'd3, 12'hfff);
        send_cycle(1, tid_pkg::OPC_ADD, 3'd7, 3'd6, 3'd7, 12'h000);
        send_cycle(1, tid_pkg::OPC_MUL, 3'd5, 3'd2, 3'd2, 12'h000);
        send_cycle(1, tid_pkg::OPC_DIV, 3'd0, 3'd5, 3'd0, 12'h000);
        send_cycle(1, tid_pkg::OPC_DIV, 3'd1, 3'd4, 3'd2, 12'h000);
        send_cycle(1, OPC_BAD_FIRST, 3'd1, 3'd1, 3'd1, 12'h000);
        send_cycle(1, OPC_BAD_LAST, 3'd2, 3'd1, 3'd1, 12'h000);
        send_cycle(0, tid_pkg::OPC_ADD, 3'd1, 3'd1, 3'd1, 12'h000);
        repeat (3) send_cycle(1, tid_pkg::OPC_ADD, 3'd2, 3'd2, 3'd2, 12'h000);
        repeat (60) send_cycle(0, tid_pkg::OPC_ADD, 3'd1, 3'd1, 3'd1, 12'h000);
        // A chain of dependent adds, multiplies and a divide, sent back to back.
        drain();
        write_latency(tid_pkg::CFG_ADD_LAT, 8'd1);
        send_cycle(1, tid_pkg::OPC_ADDI, 3'd1, 3'd0, 3'd0, 12'h001);
        send_cycle(1, tid_pkg::OPC_SUB, 3'd2, 3'd0, 3'd1, 12'h000);
        send_cycle(1, tid_pkg::OPC_ADDI, 3'd3, 3'd0, 3'd0, 12'h800);
        send_cycle(1, tid_pkg::OPC_MUL, 3'd3, 3'd3, 3'd3, 12'h000);
        send_cycle(1, tid_pkg::OPC_MUL, 3'd3, 3'd3, 3'd3, 12'h000);
        repeat (5) send_cycle(1, tid_pkg::OPC_MUL, 3'd3, 3'd3, 3'd4, 12'h000);
        send_cycle(1, tid_pkg::OPC_DIV, 3'd5, 3'd3, 3'd2, 12'h000);

        random_phase(300, 8'd2, 8'd10, 8'd40);
        random_phase(250, 8'd0, 8'd0, 8'd0);
        random_phase(150, 8'd255, 8'd255, 8'd255);
        random_phase(300, 8'd1, 8'd3, 8'd7);
        calm = 1;
        random_phase(250, 8'd4, 8'd2, 8'd12);
        calm = 0;

        drain();
        $display("Sent %0d machine cycles and checked %0d output words,", words_in, words_out);
        $display("covering all five operations over six latency settings.");
        if (errors == 0)
            $display("tomasulo_issue_dispatch_writeback verification clean");
        else
            $display("tomasulo_issue_dispatch_writeback verification failed");
        $finish;
    end

endmodule

// ----- tomasulo_issue_dispatch_writeback.f -----
design/tid_pkg.sv
design/tid_ctrl.sv
design/tid_dp.sv
design/tomasulo_issue_dispatch_writeback.sv
verif/tid_scoreboard.sv
verif/tb_tomasulo_issue_dispatch_writeback.sv
